>>> rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, lane row layout and result record for the swing pivot
// detector.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int PIVOT_LEFT  = 2;
  localparam int PIVOT_RIGHT = 2;
  localparam int LANE_COUNT  = 4;
  localparam int PRICE_BITS  = 32;

  localparam int WIN_SIZE = PIVOT_LEFT + PIVOT_RIGHT + 1;
  localparam int FILL_W   = $clog2(WIN_SIZE + 1);
  localparam int LANE_W   = 2;

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [LANE_W-1:0]     lane_t;
  typedef logic [FILL_W-1:0]     fill_t;

  typedef enum logic [1:0] {
    LABEL_NONE   = 2'd0,
    LABEL_HIGHER = 2'd1,
    LABEL_LOWER  = 2'd2
  } label_t;

  // One memory row holds everything a lane keeps; window is oldest first.
  typedef struct packed {
    price_t [WIN_SIZE-1:0] highs;
    price_t [WIN_SIZE-1:0] lows;
    fill_t                 fill;
    price_t                prev_high;
    logic                  prev_high_vld;
    price_t                prev_low;
    logic                  prev_low_vld;
  } lane_row_t;

  typedef struct packed {
    logic   high_found;
    label_t high_label;
    price_t high_price;
    logic   low_found;
    label_t low_label;
    price_t low_price;
    lane_t  lane;
  } result_t;

endpackage

>>> rtl/spd_in_if.sv
// ----------------------------------------------------------------------------
// spd_in_if
// Bar channel: valid/ready handshake with lane tag and bar high/low prices.
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic                  valid;
  logic                  ready;
  spd_pkg::lane_t        lane;
  spd_pkg::price_t       bar_high;
  spd_pkg::price_t       bar_low;

  modport source (output valid, output lane, output bar_high, output bar_low, input ready);
  modport sink   (input valid, input lane, input bar_high, input bar_low, output ready);
endinterface

>>> rtl/spd_out_if.sv
// ----------------------------------------------------------------------------
// spd_out_if
// Pivot result channel: valid/ready handshake with swing high/low findings.
// ----------------------------------------------------------------------------
interface spd_out_if;
  logic                  valid;
  logic                  ready;
  logic                  swing_high_found;
  logic [1:0]            swing_high_label;
  spd_pkg::price_t       swing_high_price;
  logic                  swing_low_found;
  logic [1:0]            swing_low_label;
  spd_pkg::price_t       swing_low_price;
  spd_pkg::lane_t        result_lane;

  modport source (output valid, output swing_high_found, output swing_high_label,
                  output swing_high_price, output swing_low_found, output swing_low_label,
                  output swing_low_price, output result_lane, input ready);
  modport sink   (input valid, input swing_high_found, input swing_high_label,
                  input swing_high_price, input swing_low_found, input swing_low_label,
                  input swing_low_price, input result_lane, output ready);
endinterface

>>> rtl/spd_lane_ram.sv
// ----------------------------------------------------------------------------
// spd_lane_ram
// Per-lane state memory, one row per lane, registered read. A row valid bit
// per lane makes a never-written row read back as the reset state.
// ----------------------------------------------------------------------------
module spd_lane_ram (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  spd_pkg::lane_t     rd_addr,
  output spd_pkg::lane_row_t rd_row,
  input  logic               wr_en,
  input  spd_pkg::lane_t     wr_addr,
  input  spd_pkg::lane_row_t wr_row
);

  spd_pkg::lane_row_t              mem [spd_pkg::LANE_COUNT];
  spd_pkg::lane_row_t              rd_q;
  logic                            rd_vld;
  logic [spd_pkg::LANE_COUNT-1:0]  row_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= row_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (wr_en) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

  // Window contents of an unwritten row are never looked at.
  always_comb begin
    rd_row = rd_q;
    if (!rd_vld) begin
      rd_row.fill          = '0;
      rd_row.prev_high     = '0;
      rd_row.prev_high_vld = 1'b0;
      rd_row.prev_low      = '0;
      rd_row.prev_low_vld  = 1'b0;
    end
  end

endmodule

>>> rtl/spd_pivot_eval.sv
// ----------------------------------------------------------------------------
// spd_pivot_eval
// Shifts the new bar into a lane row, tests the middle bar against its
// neighbours and labels any swing against the lane's previous one.
// ----------------------------------------------------------------------------
module spd_pivot_eval (
  input  spd_pkg::lane_t     lane,
  input  spd_pkg::price_t    bar_high,
  input  spd_pkg::price_t    bar_low,
  input  spd_pkg::lane_row_t old_row,
  output spd_pkg::lane_row_t new_row,
  output logic               wr_en,
  output spd_pkg::result_t   res
);

  logic            lane_ok;
  logic            full;
  logic            is_high;
  logic            is_low;
  spd_pkg::price_t th;
  spd_pkg::price_t tl;

  assign lane_ok = ({1'b0, lane} < (spd_pkg::LANE_W + 1)'(spd_pkg::LANE_COUNT));
  assign wr_en   = lane_ok;

  always_comb begin
    new_row = old_row;
    for (int k = 0; k < spd_pkg::WIN_SIZE - 1; k++) begin
      new_row.highs[k] = old_row.highs[k+1];
      new_row.lows[k]  = old_row.lows[k+1];
    end
    new_row.highs[spd_pkg::WIN_SIZE-1] = bar_high;
    new_row.lows[spd_pkg::WIN_SIZE-1]  = bar_low;
    if (old_row.fill < spd_pkg::FILL_W'(spd_pkg::WIN_SIZE)) begin
      new_row.fill = old_row.fill + spd_pkg::FILL_W'(1);
    end
    full = (new_row.fill == spd_pkg::FILL_W'(spd_pkg::WIN_SIZE));

    th      = new_row.highs[spd_pkg::PIVOT_LEFT];
    tl      = new_row.lows[spd_pkg::PIVOT_LEFT];
    is_high = 1'b1;
    is_low  = 1'b1;
    for (int k = 0; k < spd_pkg::WIN_SIZE; k++) begin
      if (k != spd_pkg::PIVOT_LEFT) begin
        if (!(th > new_row.highs[k])) is_high = 1'b0;
        if (!(tl < new_row.lows[k]))  is_low  = 1'b0;
      end
    end

    res      = '0;
    res.lane = lane;
    if (lane_ok && full && is_high) begin
      res.high_found = 1'b1;
      res.high_price = th;
      if (!old_row.prev_high_vld) begin
        res.high_label = spd_pkg::LABEL_NONE;
      end else if (th > old_row.prev_high) begin
        res.high_label = spd_pkg::LABEL_HIGHER;
      end else begin
        res.high_label = spd_pkg::LABEL_LOWER;
      end
      new_row.prev_high     = th;
      new_row.prev_high_vld = 1'b1;
    end
    if (lane_ok && full && is_low) begin
      res.low_found = 1'b1;
      res.low_price = tl;
      if (!old_row.prev_low_vld) begin
        res.low_label = spd_pkg::LABEL_NONE;
      end else if (tl > old_row.prev_low) begin
        res.low_label = spd_pkg::LABEL_HIGHER;
      end else begin
        res.low_label = spd_pkg::LABEL_LOWER;
      end
      new_row.prev_low     = tl;
      new_row.prev_low_vld = 1'b1;
    end
  end

endmodule

>>> rtl/swing_pivot_detector_core.sv
// ----------------------------------------------------------------------------
// swing_pivot_detector_core
// Fractal swing pivot detector over several timeframe lanes, lane state kept
// in a row memory with read, evaluate and write-back.
// ----------------------------------------------------------------------------
//   port       dir   payload                                  transaction
//   bar_in     in    lane, bar_high, bar_low                  one closed bar
//   pivot_out  out   swing high/low found, label, price, lane one result per bar
//
// One bar per cycle sustained while results are taken; the lane row is read
// at the accepting edge, and evaluation and write-back finish as the bar leaves
// stage 1, which also loads the result register that presents the result.
// A bar on the lane written in the cycle of its read picks up the row from
// the forwarding register. Reset is synchronous and needs no clearing pass.
// A stalled result holds one bar in evaluation; bar_in then takes no more.
// ----------------------------------------------------------------------------
module swing_pivot_detector_core (
  input logic      clk,
  input logic      rst,
  spd_in_if.sink   bar_in,
  spd_out_if.source pivot_out
);

  logic               in_acc;
  logic               s1_valid;
  logic               s1_adv;
  logic               s1_fwd;
  spd_pkg::lane_t     s1_lane;
  spd_pkg::price_t    s1_high;
  spd_pkg::price_t    s1_low;
  spd_pkg::lane_row_t rd_row;
  spd_pkg::lane_row_t fwd_row;
  spd_pkg::lane_row_t old_row;
  spd_pkg::lane_row_t new_row;
  logic               eval_wr;
  logic               wr_fire;
  spd_pkg::result_t   eval_res;
  spd_pkg::result_t   out_res;
  logic               out_valid;

  assign s1_adv       = s1_valid && (!out_valid || pivot_out.ready);
  assign bar_in.ready = !s1_valid || s1_adv;
  assign in_acc       = bar_in.valid && bar_in.ready;
  assign wr_fire      = s1_adv && eval_wr;
  assign old_row      = s1_fwd ? fwd_row : rd_row;

  spd_lane_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (bar_in.lane),
    .rd_row  (rd_row),
    .wr_en   (wr_fire),
    .wr_addr (s1_lane),
    .wr_row  (new_row)
  );

  spd_pivot_eval u_eval (
    .lane     (s1_lane),
    .bar_high (s1_high),
    .bar_low  (s1_low),
    .old_row  (old_row),
    .new_row  (new_row),
    .wr_en    (eval_wr),
    .res      (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (pivot_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_lane <= bar_in.lane;
      s1_high <= bar_in.bar_high;
      s1_low  <= bar_in.bar_low;
      // memory read races the write-back on this edge: take the written row
      s1_fwd  <= wr_fire && (s1_lane == bar_in.lane);
    end
    if (wr_fire) begin
      fwd_row <= new_row;
    end
    if (s1_adv) begin
      out_res <= eval_res;
    end
  end

  assign pivot_out.valid            = out_valid;
  assign pivot_out.swing_high_found = out_res.high_found;
  assign pivot_out.swing_high_label = out_res.high_label;
  assign pivot_out.swing_high_price = out_res.high_price;
  assign pivot_out.swing_low_found  = out_res.low_found;
  assign pivot_out.swing_low_label  = out_res.low_label;
  assign pivot_out.swing_low_price  = out_res.low_price;
  assign pivot_out.result_lane      = out_res.lane;

endmodule

>>> rtl/spd_checker.sv
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks on the swing pivot detector, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            high_found,
  input logic [1:0]      high_label,
  input spd_pkg::price_t high_price,
  input logic            low_found,
  input logic [1:0]      low_label,
  input spd_pkg::price_t low_price
);

  // a stalled result keeps its transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(high_price) && $stable(low_price))
    else $error("stalled result changed");

  // a taken bar is followed by a valid result on the output
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing after accepted bar");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !high_found |->
      high_label == spd_pkg::LABEL_NONE && high_price == '0)
    else $error("swing high fields set without a swing high");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !low_found |->
      low_label == spd_pkg::LABEL_NONE && low_price == '0)
    else $error("swing low fields set without a swing low");

endmodule

bind swing_pivot_detector_core spd_checker u_spd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (bar_in.valid),
  .in_ready   (bar_in.ready),
  .out_valid  (pivot_out.valid),
  .out_ready  (pivot_out.ready),
  .high_found (pivot_out.swing_high_found),
  .high_label (pivot_out.swing_high_label),
  .high_price (pivot_out.swing_high_price),
  .low_found  (pivot_out.swing_low_found),
  .low_label  (pivot_out.swing_low_label),
  .low_price  (pivot_out.swing_low_price)
);
